>>> rtl/wcfr_pkg.sv
// ----------------------------------------------------------------------------
// wcfr_pkg: shared types and constants of the wavetable cubic frame reader
// Field widths, command format between front and back, back-end states and
// the fixed-point constants of the Catmull-Rom datapath.
// ----------------------------------------------------------------------------
package wcfr_pkg;

    // Default geometry of the table
    localparam int FRAME_SIZE_DEF = 2048;
    localparam int MAX_FRAMES_DEF = 16;

    // Widest address and in-frame position over the whole parameter range
    localparam int ADDR_MAX_W = 21;
    localparam int POS_MAX_W  = 13;

    // Channel field widths
    localparam int ADDR_IN_W   = 15;
    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 32;
    localparam int FRAME_IDX_W = 4;
    localparam int FRAC_W      = 16;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam logic             OPC_WRITE = 1'b0;
    localparam logic             OPC_READ  = 1'b1;

    // Accumulator holds twice the value in units of 2^-16
    localparam int ACC_W = 40;
    localparam int MUL_W = ACC_W + FRAC_W + 1;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-32768);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_WRITE,
        K_READ,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_kind                                kind;
        logic [ADDR_MAX_W-1:0]                addr;
        logic signed [SAMPLE_W-1:0]           wdata;
        logic [ADDR_MAX_W-1:0]                base0;
        logic [ADDR_MAX_W-1:0]                base1;
        logic [3:0][POS_MAX_W-1:0]            taps;
        logic [FRAC_W-1:0]                    t;
        logic [FRAC_W-1:0]                    blend;
        logic                                 use_next;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_COEF,
        S_MAC,
        S_DIFF,
        S_BLEND,
        S_OUT
    } t_back_state;

endpackage

>>> rtl/wcfr_in_if.sv
// ----------------------------------------------------------------------------
// wcfr_in_if: item channel of the wavetable cubic frame reader
// Carries write and read items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcfr_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [wcfr_pkg::ADDR_IN_W-1:0]      write_address;
    logic signed [wcfr_pkg::SAMPLE_W-1:0] write_sample;
    logic [wcfr_pkg::PHASE_W-1:0]        phase;
    logic [wcfr_pkg::FRAME_IDX_W-1:0]    frame_index;
    logic [wcfr_pkg::FRAC_W-1:0]         frame_blend;

    modport source (
        output valid, opcode, write_address, write_sample, phase, frame_index, frame_blend,
        input  ready
    );
    modport sink (
        input  valid, opcode, write_address, write_sample, phase, frame_index, frame_blend,
        output ready
    );
endinterface

>>> rtl/wcfr_out_if.sv
// ----------------------------------------------------------------------------
// wcfr_out_if: result channel of the wavetable cubic frame reader
// Carries one interpolated sample per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcfr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wcfr_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

>>> rtl/wcfr_cfg_if.sv
// ----------------------------------------------------------------------------
// wcfr_cfg_if: configuration write channel
// Carries the frames-in-use register value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wcfr_pkg::CFG_W-1:0]     frames_in_use;

    modport source (output valid, frames_in_use, input ready);
    modport sink (input valid, frames_in_use, output ready);
endinterface

>>> rtl/wcfr_front.sv
// ----------------------------------------------------------------------------
// wcfr_front: item classifier
// Turns an accepted beat into a queue command: write, interpolated read or
// zero read; works out the phase position, fraction, wrapped taps and bases.
// ----------------------------------------------------------------------------
module wcfr_front #(
    parameter int FRAME_SIZE = wcfr_pkg::FRAME_SIZE_DEF,
    parameter int MAX_FRAMES = wcfr_pkg::MAX_FRAMES_DEF
) (
    wcfr_in_if.sink                 i_in,
    input  logic [wcfr_pkg::CFG_W-1:0] i_frames_in_use,
    output logic                    o_cmd_valid,
    output wcfr_pkg::t_cmd          o_cmd,
    input  logic                    i_cmd_ready
);

    localparam int DEPTH  = FRAME_SIZE * MAX_FRAMES;
    localparam int PW     = $clog2(FRAME_SIZE);
    localparam int PROD_W = wcfr_pkg::PHASE_W + PW;

    localparam logic [PW:0] FS_E = (PW + 1)'(FRAME_SIZE);
    localparam logic [PW:0] ONE  = (PW + 1)'(1);
    localparam logic [PW:0] TWO  = (PW + 1)'(2);

    logic [PROD_W-1:0]              w_prod;
    logic [PW:0]                    w_pos;
    logic [PW:0]                    w_p1;
    logic [PW:0]                    w_p2;
    logic [PW:0]                    w_xm1;
    logic [PW:0]                    w_x1;
    logic [PW:0]                    w_x2;
    logic [wcfr_pkg::CFG_W-1:0]     w_count;
    logic [wcfr_pkg::CFG_W-1:0]     w_frame;
    logic [wcfr_pkg::CFG_W-1:0]     w_next;
    logic                           w_in_use;
    logic                           w_next_use;
    logic                           w_is_read;
    logic                           w_in_range;

    // Position and fraction of the phase inside one frame
    assign w_prod = PROD_W'(i_in.phase) * PROD_W'(FRAME_SIZE);
    assign w_pos  = {1'b0, w_prod[PROD_W-1:wcfr_pkg::PHASE_W]};

    // Wrap neighbor positions inside the frame
    always_comb begin
        w_p1  = w_pos + ONE;
        w_p2  = w_pos + TWO;
        w_xm1 = (w_pos == '0) ? (FS_E - ONE) : (w_pos - ONE);
        w_x1  = (w_p1 == FS_E) ? '0 : w_p1;
        w_x2  = (w_p2 >= FS_E) ? (w_p2 - FS_E) : w_p2;
    end

    // Clamp the loaded frame count to the table size
    always_comb begin
        if (int'(i_frames_in_use) > MAX_FRAMES) begin
            w_count = wcfr_pkg::CFG_W'(MAX_FRAMES);
        end else begin
            w_count = i_frames_in_use;
        end
    end

    assign w_frame    = {1'b0, i_in.frame_index};
    assign w_next     = w_frame + wcfr_pkg::CFG_W'(1);
    assign w_in_use   = (w_frame < w_count);
    assign w_next_use = (w_next < w_count);
    assign w_is_read  = (i_in.opcode == wcfr_pkg::OPC_READ);
    assign w_in_range = (32'(i_in.write_address) < 32'(DEPTH));

    // Build the command
    always_comb begin
        if (!w_is_read) begin
            o_cmd.kind = wcfr_pkg::K_WRITE;
        end else if (w_in_use) begin
            o_cmd.kind = wcfr_pkg::K_READ;
        end else begin
            o_cmd.kind = wcfr_pkg::K_ZERO;
        end
        o_cmd.addr     = wcfr_pkg::ADDR_MAX_W'(i_in.write_address);
        o_cmd.wdata    = i_in.write_sample;
        o_cmd.base0    = wcfr_pkg::ADDR_MAX_W'(w_frame) * wcfr_pkg::ADDR_MAX_W'(FRAME_SIZE);
        o_cmd.base1    = wcfr_pkg::ADDR_MAX_W'(w_next) * wcfr_pkg::ADDR_MAX_W'(FRAME_SIZE);
        o_cmd.taps[0]  = wcfr_pkg::POS_MAX_W'(w_xm1);
        o_cmd.taps[1]  = wcfr_pkg::POS_MAX_W'(w_pos);
        o_cmd.taps[2]  = wcfr_pkg::POS_MAX_W'(w_x1);
        o_cmd.taps[3]  = wcfr_pkg::POS_MAX_W'(w_x2);
        o_cmd.t        = w_prod[wcfr_pkg::PHASE_W-1:wcfr_pkg::PHASE_W-wcfr_pkg::FRAC_W];
        o_cmd.blend    = i_in.frame_blend;
        o_cmd.use_next = (i_in.frame_blend != '0) && w_next_use;
    end

    // Drop writes beyond the table; they are taken but never queued
    assign o_cmd_valid = i_in.valid && (w_is_read || w_in_range);
    assign i_in.ready  = i_cmd_ready;

endmodule

>>> rtl/wcfr_fifo.sv
// ----------------------------------------------------------------------------
// wcfr_fifo: command queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module wcfr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  wcfr_pkg::t_cmd i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output wcfr_pkg::t_cmd o_pop_data
);

    localparam int PTR_W = $clog2(wcfr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    wcfr_pkg::t_cmd   r_mem [wcfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(wcfr_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Advance pointers and occupancy; depth is a power of two so pointers wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/wcfr_back.sv
// ----------------------------------------------------------------------------
// wcfr_back: table and interpolation engine
// Owns the single-port wavetable, executes writes, reads four taps per frame,
// runs Horner steps and the frame blend on one shared multiplier, and holds
// the finished sample in an output register.
// ----------------------------------------------------------------------------
module wcfr_back #(
    parameter int FRAME_SIZE = wcfr_pkg::FRAME_SIZE_DEF,
    parameter int MAX_FRAMES = wcfr_pkg::MAX_FRAMES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    output logic                                 o_cmd_ready,
    input  wcfr_pkg::t_cmd                       i_cmd,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [wcfr_pkg::SAMPLE_W-1:0] o_out_sample
);

    localparam int DEPTH = FRAME_SIZE * MAX_FRAMES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = wcfr_pkg::ACC_W;
    localparam int MUL_W = wcfr_pkg::MUL_W;
    localparam int FRAC_W = wcfr_pkg::FRAC_W;

    // Table and registers
    logic [wcfr_pkg::SAMPLE_W-1:0]        r_mem [DEPTH];
    logic signed [wcfr_pkg::SAMPLE_W-1:0] r_x [4];
    wcfr_pkg::t_back_state                r_state;
    wcfr_pkg::t_back_state                n_state;
    wcfr_pkg::t_cmd                       r_cmd;
    logic [1:0]                           r_tap;
    logic [1:0]                           r_step;
    logic                                 r_frame1;
    logic                                 r_out_valid;
    logic signed [wcfr_pkg::SAMPLE_W-1:0] r_out_sample;
    logic signed [ACC_W-1:0]              r_acc;
    logic signed [ACC_W-1:0]              r_a0;
    logic signed [ACC_W-1:0]              r_c1;
    logic signed [ACC_W-1:0]              r_c2;

    // Control
    logic                                 w_pop;
    logic                                 w_mem_we;
    logic                                 w_mem_re;
    logic                                 w_out_load;
    logic                                 w_out_zero;
    logic                                 w_out_free;
    logic [AW-1:0]                        w_mem_addr;
    logic [AW-1:0]                        w_rd_addr;
    logic [wcfr_pkg::ADDR_MAX_W-1:0]      w_base;

    // Datapath
    logic signed [ACC_W-1:0]              w_xm1;
    logic signed [ACC_W-1:0]              w_x0;
    logic signed [ACC_W-1:0]              w_x1;
    logic signed [ACC_W-1:0]              w_x2;
    logic signed [ACC_W-1:0]              w_d01;
    logic signed [ACC_W-1:0]              w_c1;
    logic signed [ACC_W-1:0]              w_c2;
    logic signed [ACC_W-1:0]              w_c3;
    logic signed [FRAC_W:0]               w_k;
    logic signed [MUL_W-1:0]              w_prod;
    logic signed [ACC_W-1:0]              w_scaled;
    logic signed [ACC_W-1:0]              w_addend;
    logic signed [ACC_W-1:0]              w_mac;
    logic signed [ACC_W-1:0]              w_round;
    logic signed [ACC_W-1:0]              w_shift;
    logic signed [wcfr_pkg::SAMPLE_W-1:0] w_sat;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_cmd_ready  = w_pop;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

    // Next state and control
    always_comb begin
        n_state    = r_state;
        w_pop      = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_out_load = 1'b0;
        w_out_zero = 1'b0;
        case (r_state)
            wcfr_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        wcfr_pkg::K_WRITE: begin
                            w_pop    = 1'b1;
                            w_mem_we = 1'b1;
                        end
                        wcfr_pkg::K_READ: begin
                            w_pop   = 1'b1;
                            n_state = wcfr_pkg::S_TAP;
                        end
                        wcfr_pkg::K_ZERO: begin
                            if (w_out_free) begin
                                w_pop      = 1'b1;
                                w_out_load = 1'b1;
                                w_out_zero = 1'b1;
                            end
                        end
                        default: begin
                            w_pop = 1'b1;
                        end
                    endcase
                end
            end
            wcfr_pkg::S_TAP: begin
                w_mem_re = 1'b1;
                if (r_tap == 2'd3) begin
                    n_state = wcfr_pkg::S_COEF;
                end
            end
            wcfr_pkg::S_COEF: begin
                n_state = wcfr_pkg::S_MAC;
            end
            wcfr_pkg::S_MAC: begin
                if (r_step == 2'd2) begin
                    if (r_frame1) begin
                        n_state = wcfr_pkg::S_DIFF;
                    end else if (r_cmd.use_next) begin
                        n_state = wcfr_pkg::S_TAP;
                    end else begin
                        n_state = wcfr_pkg::S_OUT;
                    end
                end
            end
            wcfr_pkg::S_DIFF: begin
                n_state = wcfr_pkg::S_BLEND;
            end
            wcfr_pkg::S_BLEND: begin
                n_state = wcfr_pkg::S_OUT;
            end
            wcfr_pkg::S_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = wcfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wcfr_pkg::S_IDLE;
            end
        endcase
    end

    // Table port: one access per cycle, write from the queue head or tap read
    assign w_base     = r_frame1 ? r_cmd.base1 : r_cmd.base0;
    assign w_rd_addr  = AW'(w_base) + AW'(r_cmd.taps[r_tap]);
    assign w_mem_addr = w_mem_we ? AW'(i_cmd.addr) : w_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= i_cmd.wdata;
        end
        if (w_mem_re) begin
            r_x[r_tap] <= r_mem[w_mem_addr];
        end
    end

    // Doubled Catmull-Rom coefficients from the four taps
    always_comb begin
        w_xm1 = ACC_W'(r_x[0]);
        w_x0  = ACC_W'(r_x[1]);
        w_x1  = ACC_W'(r_x[2]);
        w_x2  = ACC_W'(r_x[3]);
        w_d01 = w_x0 - w_x1;
        w_c1  = w_x1 - w_xm1;
        w_c2  = (w_xm1 <<< 1) - ((w_x0 <<< 2) + w_x0) + (w_x1 <<< 2) - w_x2;
        w_c3  = (w_x2 - w_xm1) + (w_d01 <<< 1) + w_d01;
    end

    // Shared multiply, floor shift and add: Horner steps and the blend
    always_comb begin
        if (r_state == wcfr_pkg::S_BLEND) begin
            w_k      = {1'b0, r_cmd.blend};
            w_addend = r_a0;
        end else begin
            w_k = {1'b0, r_cmd.t};
            case (r_step)
                2'd0:    w_addend = r_c2;
                2'd1:    w_addend = r_c1;
                default: w_addend = w_x0 <<< (FRAC_W + 1);
            endcase
        end
        w_prod   = MUL_W'(r_acc) * MUL_W'(w_k);
        w_scaled = w_prod[FRAC_W +: ACC_W];
        w_mac    = w_scaled + w_addend;
    end

    // Round half up and saturate to the sample range
    always_comb begin
        w_round = r_acc + wcfr_pkg::ROUND_BIAS;
        w_shift = w_round >>> (FRAC_W + 1);
        if (w_shift > wcfr_pkg::SAT_HI) begin
            w_sat = wcfr_pkg::SAT_HI[wcfr_pkg::SAMPLE_W-1:0];
        end else if (w_shift < wcfr_pkg::SAT_LO) begin
            w_sat = wcfr_pkg::SAT_LO[wcfr_pkg::SAMPLE_W-1:0];
        end else begin
            w_sat = w_shift[wcfr_pkg::SAMPLE_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wcfr_pkg::S_IDLE;
            r_tap       <= '0;
            r_step      <= '0;
            r_frame1    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Four taps per frame: the counter wraps back to zero by itself
            if (w_mem_re) begin
                r_tap <= r_tap + 2'd1;
            end
            if (r_state == wcfr_pkg::S_MAC) begin
                r_step <= (r_step == 2'd2) ? 2'd0 : r_step + 2'd1;
            end
            if (w_pop) begin
                r_frame1 <= 1'b0;
            end else if (r_state == wcfr_pkg::S_MAC && r_step == 2'd2 && !r_frame1 &&
                         r_cmd.use_next) begin
                r_frame1 <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            wcfr_pkg::S_COEF: begin
                r_acc <= w_c3 <<< FRAC_W;
                r_c1  <= w_c1 <<< FRAC_W;
                r_c2  <= w_c2 <<< FRAC_W;
            end
            wcfr_pkg::S_MAC: begin
                r_acc <= w_mac;
                if (r_step == 2'd2 && !r_frame1) begin
                    r_a0 <= w_mac;
                end
            end
            wcfr_pkg::S_DIFF: begin
                r_acc <= r_acc - r_a0;
            end
            wcfr_pkg::S_BLEND: begin
                r_acc <= w_mac;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (w_out_load) begin
            r_out_sample <= w_out_zero ? '0 : w_sat;
        end
    end

`ifndef ASSERT_OFF
    a_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("table written and read in the same cycle");

    a_tap_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wcfr_pkg::S_TAP) |-> (r_cmd.kind == wcfr_pkg::K_READ))
        else $error("tap fetch for a command that is not a read");

    a_second_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame1 |-> r_cmd.use_next)
        else $error("second frame fetched without blend");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a sample not yet taken");

    a_refetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wcfr_pkg::S_MAC && r_step == 2'd2 && !r_frame1 && r_cmd.use_next)
        |=> (r_state == wcfr_pkg::S_TAP && r_tap == 2'd0 && r_frame1))
        else $error("next frame fetch did not restart at the first tap");
`endif

endmodule

>>> rtl/wavetable_cubic_frame_reader.sv
// ----------------------------------------------------------------------------
// wavetable_cubic_frame_reader: wavetable with Catmull-Rom frame reads
// Usage:
//   i_in carries items. opcode write stores write_sample at write_address
//   (addresses beyond the table are dropped); opcode read interpolates the
//   frame frame_index at phase and, with a non-zero frame_blend and a next
//   frame in use, blends in the next frame. Each read gives one beat on
//   o_out; a write gives none. i_cfg sets frames_in_use and is always ready;
//   write it only while no item is in flight.
//   Engine steps per item: a write, or a read of a frame not in use, is
//   done in the idle state; a single-frame read runs four tap reads, the
//   coefficient step, three Horner steps and the output state; a blended
//   read runs taps, coefficients and Horner steps for both frames, then the
//   difference and blend steps. The single-port table and the one shared
//   multiplier set these steps. Items queued ahead of a read delay it.
//   A four-entry queue lets i_in keep taking beats while the engine works,
//   and the output register holds a finished sample while o_out stalls;
//   the engine then stops before it loads the next result.
//   Reset empties the queue and the output, and sets frames_in_use to 16.
//   Table contents are not cleared and stay undefined until written.
// ----------------------------------------------------------------------------
module wavetable_cubic_frame_reader #(
    parameter int FRAME_SIZE = wcfr_pkg::FRAME_SIZE_DEF,
    parameter int MAX_FRAMES = wcfr_pkg::MAX_FRAMES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wcfr_in_if.sink      i_in,
    wcfr_cfg_if.sink     i_cfg,
    wcfr_out_if.source   o_out
);

    logic [wcfr_pkg::CFG_W-1:0] r_frames_in_use;
    logic                       w_push_valid;
    logic                       w_push_ready;
    wcfr_pkg::t_cmd             w_push_cmd;
    logic                       w_pop_valid;
    logic                       w_pop_ready;
    wcfr_pkg::t_cmd             w_pop_cmd;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= wcfr_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            r_frames_in_use <= i_cfg.frames_in_use;
        end
    end

    // Classify accepted beats
    wcfr_front #(
        .FRAME_SIZE (FRAME_SIZE),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_in            (i_in),
        .i_frames_in_use (r_frames_in_use),
        .o_cmd_valid     (w_push_valid),
        .o_cmd           (w_push_cmd),
        .i_cmd_ready     (w_push_ready)
    );

    // Queue commands between front and back
    wcfr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_cmd)
    );

    // Execute commands against the table
    wcfr_back #(
        .FRAME_SIZE (FRAME_SIZE),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_pop_valid),
        .o_cmd_ready  (w_pop_ready),
        .i_cmd        (w_pop_cmd),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_sample (o_out.sample)
    );

endmodule

>>> test/tb_wavetable_cubic_frame_reader.sv
// ----------------------------------------------------------------------------
// tb_wavetable_cubic_frame_reader: self-checking bench for the frame reader
// Loads table taps through write beats and sends read beats. Each read is
// predicted with a bit-exact Catmull-Rom and frame-blend predictor that is
// kept next to a copy of the table. Results are checked in order against the
// prediction, under random source gaps and sink stalls and several
// frames_in_use settings.
// ----------------------------------------------------------------------------
module tb_wavetable_cubic_frame_reader;

    localparam int FS       = wcfr_pkg::FRAME_SIZE_DEF;
    localparam int NF       = wcfr_pkg::MAX_FRAMES_DEF;
    localparam int DEPTH    = FS * NF;
    localparam int AW       = $clog2(DEPTH);
    localparam int POS_BITS = $clog2(FS);
    localparam int SETTLE   = 64;

    typedef struct {
        logic                                  opcode;
        logic [wcfr_pkg::ADDR_IN_W-1:0]        addr;
        logic signed [wcfr_pkg::SAMPLE_W-1:0]  wsample;
        logic [wcfr_pkg::PHASE_W-1:0]          phase;
        logic [wcfr_pkg::FRAME_IDX_W-1:0]      frame;
        logic [wcfr_pkg::FRAC_W-1:0]           blend;
    } t_item;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wcfr_in_if  in_if ();
    wcfr_cfg_if cfg_if ();
    wcfr_out_if out_if ();

    wavetable_cubic_frame_reader i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Beats waiting to be sent and samples waiting to come back
    t_item                                pending_items[$];
    logic signed [wcfr_pkg::SAMPLE_W-1:0] expected_samples[$];
    t_item                                item_on_bus;
    bit                                   holding_item = 1'b0;

    // Bench copy of the table and of the register
    logic signed [wcfr_pkg::SAMPLE_W-1:0] wave_mem [DEPTH];
    logic [wcfr_pkg::CFG_W-1:0]           frames_cfg = wcfr_pkg::CFG_RESET;
    bit                                   written_map [DEPTH];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_queued   = 0;
    int err_count      = 0;
    int writes_done    = 0;
    int samples_checked = 0;
    int cfg_writes     = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[wavetable_cubic_frame_reader] ERROR");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Twice the interpolated value of one frame, in units of 2^-16
    function automatic longint frame_twice(input int unsigned frame, input logic [31:0] ph);
        longint unsigned prod;
        int unsigned     pos;
        int unsigned     base;
        longint t, xm1, x0, x1, x2, c1, c2, c3, a;
        prod = {32'b0, ph} * FS;
        pos  = int'(prod >> 32);
        t    = longint'((prod >> 16) & 64'hFFFF);
        base = frame * FS;
        xm1  = wave_mem[AW'(base + (pos + FS - 1) % FS)];
        x0   = wave_mem[AW'(base + pos % FS)];
        x1   = wave_mem[AW'(base + (pos + 1) % FS)];
        x2   = wave_mem[AW'(base + (pos + 2) % FS)];
        c1   = x1 - xm1;
        c2   = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
        c3   = (x2 - xm1) + 3 * (x0 - x1);
        a    = c3 * t + c2 * 65536;
        a    = ((a * t) >>> 16) + c1 * 65536;
        a    = ((a * t) >>> 16) + 2 * x0 * 65536;
        return a;
    endfunction

    // Apply one accepted beat to the table copy, queue the sample a read gives
    function automatic void predict_beat(input t_item it);
        int unsigned count;
        longint      r, b, bl, s;
        if (it.opcode == wcfr_pkg::OPC_WRITE) begin
            if (it.addr < DEPTH)
                wave_mem[it.addr] = it.wsample;
            writes_done++;
        end else begin
            count = (frames_cfg > NF) ? NF : frames_cfg;
            s = 0;
            if (it.frame < count) begin
                r = frame_twice(it.frame, it.phase);
                bl = it.blend;
                if (bl != 0 && it.frame + 1 < count) begin
                    b = frame_twice(it.frame + 1, it.phase);
                    r = r + (((b - r) * bl) >>> 16);
                end
                s = (r + 65536) >>> 17;
                if (s > 32767)
                    s = 32767;
                if (s < -32768)
                    s = -32768;
            end
            expected_samples.push_back(s[15:0]);
        end
    endfunction

    // Driver: advance to the next beat once the current one is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid         <= 1'b0;
            in_if.opcode        <= wcfr_pkg::OPC_WRITE;
            in_if.write_address <= '0;
            in_if.write_sample  <= '0;
            in_if.phase         <= '0;
            in_if.frame_index   <= '0;
            in_if.frame_blend   <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_beat(item_on_bus);
                holding_item = 1'b0;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item_on_bus = pending_items.pop_front();
                    holding_item = 1'b1;
                    in_if.opcode        <= item_on_bus.opcode;
                    in_if.write_address <= item_on_bus.addr;
                    in_if.write_sample  <= item_on_bus.wsample;
                    in_if.phase         <= item_on_bus.phase;
                    in_if.frame_index   <= item_on_bus.frame;
                    in_if.frame_blend   <= item_on_bus.blend;
                    in_if.valid         <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each sample beat against the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_samples.size() == 0) begin
                    flag_error($sformatf("sample %0d with no read pending", out_if.sample));
                end else begin
                    if (out_if.sample !== expected_samples[0])
                        flag_error($sformatf("sample got %0d, predicted %0d",
                                             out_if.sample, expected_samples[0]));
                    void'(expected_samples.pop_front());
                    samples_checked++;
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic set_pressure(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 18;
                recv_stall_pct = 79;
            end
            1: begin
                send_idle_pct  = 79;
                recv_stall_pct = 18;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic write_frames_in_use(input logic [wcfr_pkg::CFG_W-1:0] v);
        @(posedge clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.frames_in_use <= v;
        do @(posedge clk); while (!cfg_if.ready);
        frames_cfg = v;
        cfg_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for all beats out and all samples back, then let queued writes retire
    task automatic wait_engine_idle();
        while (pending_items.size() != 0 || holding_item || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        int v;
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: begin
                v = $urandom_range(0, 128);
                return 16'(v - 64);
            end
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] phase_of(input int pos, input logic [15:0] t);
        logic [POS_BITS-1:0] pv;
        logic [15-POS_BITS:0] lo;
        pv = POS_BITS'(pos);
        lo = (16 - POS_BITS)'($urandom());
        return {pv, t, lo};
    endfunction

    function automatic void push_write(input int addr, input logic signed [15:0] v);
        t_item it;
        it.opcode  = wcfr_pkg::OPC_WRITE;
        it.addr    = wcfr_pkg::ADDR_IN_W'(addr);
        it.wsample = v;
        it.phase   = $urandom();
        it.frame   = wcfr_pkg::FRAME_IDX_W'($urandom());
        it.blend   = wcfr_pkg::FRAC_W'($urandom());
        written_map[AW'(addr)] = 1'b1;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    // Load the four taps around pos; patterns 2 and 3 force overshoot
    function automatic void touch_frame(input int frame, input int pos, input bit refresh,
                                        input int vmode);
        int k;
        int addr;
        logic signed [15:0] v;
        for (k = 0; k < 4; k++) begin
            addr = frame * FS + (pos + FS - 1 + k) % FS;
            if (refresh || !written_map[AW'(addr)]) begin
                case (vmode)
                    2: v = (k == 1 || k == 2) ? 16'sd32767 : -16'sd32768;
                    3: v = (k == 1 || k == 2) ? -16'sd32768 : 16'sd32767;
                    default: v = pick_value();
                endcase
                push_write(addr, v);
            end
        end
    endfunction

    // Queue a read, preceded by writes of any tap it needs that is not loaded
    function automatic void add_read(input int frame, input logic [31:0] ph,
                                     input logic [15:0] blend, input bit refresh,
                                     input int vmode);
        t_item           it;
        int              count;
        int              pos;
        longint unsigned prod;
        count = (frames_cfg > NF) ? NF : frames_cfg;
        prod  = {32'b0, ph} * FS;
        pos   = int'(prod >> 32);
        if (frame < count) begin
            touch_frame(frame, pos, refresh, vmode);
            if (blend != 0 && frame + 1 < count)
                touch_frame(frame + 1, pos, refresh, vmode);
        end
        it.opcode  = wcfr_pkg::OPC_READ;
        it.addr    = wcfr_pkg::ADDR_IN_W'($urandom());
        it.wsample = wcfr_pkg::SAMPLE_W'($urandom());
        it.phase   = ph;
        it.frame   = wcfr_pkg::FRAME_IDX_W'(frame);
        it.blend   = blend;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    // Mostly well-formed reads near reused positions, some stray writes and raw reads
    task automatic run_random_burst(input int n);
        int stop_at;
        int sel, frame, pos, count;
        logic [15:0] t, blend;
        int hot_pos[8];
        hot_pos = '{0, 1, 2, 5, FS / 2, FS - 3, FS - 2, FS - 1};
        stop_at = items_queued + n;
        count = (frames_cfg > NF) ? NF : frames_cfg;
        while (items_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                push_write($urandom_range(0, DEPTH - 1), pick_value());
            end else if (sel < 20) begin
                add_read($urandom_range(0, NF - 1), $urandom(), 16'($urandom()), 1'b0, 0);
            end else begin
                if (count == 0 || $urandom_range(0, 3) == 0)
                    frame = $urandom_range(0, NF - 1);
                else
                    frame = $urandom_range(0, count - 1);
                pos = ($urandom_range(0, 1) == 0) ? hot_pos[3'($urandom_range(0, 7))]
                                                  : $urandom_range(0, FS - 1);
                case ($urandom_range(0, 4))
                    0: t = 16'h0000;
                    1: t = 16'hFFFF;
                    default: t = 16'($urandom());
                endcase
                case ($urandom_range(0, 5))
                    0: blend = 16'h0000;
                    1: blend = 16'hFFFF;
                    2: blend = 16'h0001;
                    default: blend = 16'($urandom());
                endcase
                add_read(frame, phase_of(pos, t), blend, $urandom_range(0, 2) == 0,
                         $urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        logic [wcfr_pkg::CFG_W-1:0] cfg_plan[6];
        int p;
        cfg_if.valid         <= 1'b0;
        cfg_if.frames_in_use <= wcfr_pkg::CFG_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        set_pressure(0);

        // Wrap at frame start, exact tap, overshoot to the upper rail
        push_write(0, 16'sd32767);
        push_write(1, 16'sd32767);
        push_write(2, -16'sd32768);
        push_write(FS - 1, -16'sd32768);
        add_read(0, phase_of(0, 16'h0000), 16'h0000, 1'b0, 0);
        add_read(0, phase_of(0, 16'h8000), 16'h0000, 1'b0, 0);
        add_read(0, phase_of(0, 16'hFFFF), 16'h0000, 1'b0, 0);

        // Last frame, last position: wrap at frame end, blend with no next frame
        push_write(DEPTH - 1, -16'sd32768);
        push_write(DEPTH - FS, -16'sd32768);
        push_write(DEPTH - FS + 1, 16'sd32767);
        push_write(DEPTH - 2, 16'sd32767);
        add_read(NF - 1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 0);
        add_read(NF - 1, phase_of(FS - 1, 16'h8000), 16'h0000, 1'b0, 0);

        // Blend into the next frame at full, smallest and half weight
        add_read(0, phase_of(0, 16'h4000), 16'hFFFF, 1'b0, 0);
        add_read(0, phase_of(0, 16'h4000), 16'h0001, 1'b0, 0);
        add_read(0, phase_of(0, 16'h4000), 16'h8000, 1'b0, 0);
        wait_engine_idle();

        // One frame in use: frame out of range, next frame missing
        write_frames_in_use(5'd1);
        add_read(3, $urandom(), 16'($urandom()), 1'b0, 0);
        add_read(0, phase_of(0, 16'h2000), 16'hFFFF, 1'b0, 0);
        wait_engine_idle();

        // No frames in use
        write_frames_in_use(5'd0);
        add_read(0, $urandom(), 16'h1234, 1'b0, 0);
        wait_engine_idle();

        cfg_plan = '{5'd31, 5'd1, 5'd12, 5'd0, 5'($urandom_range(2, 15)), 5'd16};
        for (p = 0; p < 6; p++) begin
            set_pressure(p / 2);
            write_frames_in_use(cfg_plan[3'(p)]);
            run_random_burst(160);
            wait_engine_idle();
        end

        $display("covered %0d table writes and %0d checked samples over %0d frames_in_use writes",
                 writes_done, samples_checked, cfg_writes);
        $display("settings 0, 1, 12, 16, 31 and one random, each source/sink idle mix");
        if (err_count == 0) begin
            $display("[wavetable_cubic_frame_reader] OK");
        end else begin
            $display("[wavetable_cubic_frame_reader] ERROR");
        end
        $finish;
    end

endmodule
